FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, with a disable on reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: hw/rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// types and codes shared by the mosi snooping coherence controller
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

  localparam int unsigned NUM_LINES_DEF = 256;
  localparam int unsigned LINE_INDEX_W  = 8;
  localparam int unsigned IDX_TBL_DEPTH = 1 << LINE_INDEX_W;

  // line states
  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_IS = 3'd1,
    ST_S  = 3'd2,
    ST_O  = 3'd3,
    ST_IM = 3'd4,
    ST_OM = 3'd5,
    ST_M  = 3'd6
  } line_state_t;

  // request types
  localparam logic [2:0] RQ_LOAD  = 3'd0;
  localparam logic [2:0] RQ_STORE = 3'd1;
  localparam logic [2:0] RQ_GETS  = 3'd2;
  localparam logic [2:0] RQ_GETM  = 3'd3;
  localparam logic [2:0] RQ_DATA  = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_WAIT  = 2'd1;
  localparam logic [1:0] ERR_UNEXP = 2'd2;
  localparam logic [1:0] ERR_MOD   = 2'd3;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [LINE_INDEX_W-1:0] line_index;
    logic [31:0]             addr;
    logic [3:0]              src_id;
    logic                    shared_in;
  } req_t;

  typedef struct packed {
    logic        issue_gets;
    logic        issue_getm;
    logic        data_to_proc;
    logic        data_on_bus;
    logic        assert_shared;
    logic [3:0]  data_dest;
    logic [31:0] out_addr;
    logic        miss;
    logic [1:0]  error_code;
    logic [2:0]  line_state;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msc_line_fsm.sv
// ----------------------------------------------------------------------------
// msc_line_fsm
// mosi transition of one line: next state and response flags
// ----------------------------------------------------------------------------
`default_nettype none

module msc_line_fsm
  import msc_pkg::*;
(
  input  req_t        req,
  input  line_state_t cur_state,
  output line_state_t next_state,
  output rsp_t        rsp
);

  logic is_proc;
  logic is_snoop;
  logic is_data;

  assign is_proc  = (req.req_type == RQ_LOAD) || (req.req_type == RQ_STORE);
  assign is_snoop = (req.req_type == RQ_GETS) || (req.req_type == RQ_GETM);
  assign is_data  = (req.req_type == RQ_DATA);

  // next state
  always_comb begin
    next_state = cur_state;
    if (is_proc) begin
      case (cur_state)
        ST_I:    next_state = (req.req_type == RQ_STORE) ? ST_IM : ST_IS;
        ST_S:    next_state = (req.req_type == RQ_STORE) ? ST_IM : ST_S;
        ST_O:    next_state = (req.req_type == RQ_STORE) ? ST_OM : ST_O;
        default: next_state = cur_state;
      endcase
    end else if (is_snoop) begin
      case (cur_state)
        ST_S:    next_state = (req.req_type == RQ_GETM) ? ST_I : ST_S;
        ST_O:    next_state = (req.req_type == RQ_GETM) ? ST_I : ST_O;
        ST_M:    next_state = (req.req_type == RQ_GETM) ? ST_I : ST_O;
        default: next_state = cur_state;
      endcase
    end else if (is_data) begin
      case (cur_state)
        ST_IS:   next_state = ST_S;
        ST_IM:   next_state = ST_M;
        ST_OM:   next_state = ST_M;
        default: next_state = cur_state;
      endcase
    end
  end

  // response flags
  logic       gets, getm, to_proc, on_bus, assert_sh, miss;
  logic [1:0] err;

  always_comb begin
    gets      = 1'b0;
    getm      = 1'b0;
    to_proc   = 1'b0;
    on_bus    = 1'b0;
    assert_sh = 1'b0;
    miss      = 1'b0;
    err       = ERR_NONE;
    if (is_proc) begin
      case (cur_state)
        ST_I: begin
          getm = (req.req_type == RQ_STORE);
          gets = (req.req_type == RQ_LOAD);
          miss = 1'b1;
        end
        ST_S, ST_O: begin
          getm    = (req.req_type == RQ_STORE);
          miss    = (req.req_type == RQ_STORE);
          to_proc = (req.req_type == RQ_LOAD);
        end
        ST_M:    to_proc = 1'b1;
        default: err = ERR_WAIT;
      endcase
    end else if (is_snoop) begin
      case (cur_state)
        ST_O: begin
          assert_sh = 1'b1;
          on_bus    = 1'b1;
        end
        ST_OM, ST_M: begin
          // owner supplies only while nobody else holds the shared line
          assert_sh = !req.shared_in;
          on_bus    = !req.shared_in;
        end
        default: ;
      endcase
    end else if (is_data) begin
      case (cur_state)
        ST_IS, ST_IM, ST_OM: to_proc = 1'b1;
        ST_O:    err = ERR_UNEXP;
        ST_M:    err = ERR_MOD;
        default: ;
      endcase
    end else begin
      err = ERR_UNEXP;
    end

    rsp.issue_gets    = gets;
    rsp.issue_getm    = getm;
    rsp.data_to_proc  = to_proc;
    rsp.data_on_bus   = on_bus;
    rsp.assert_shared = assert_sh;
    rsp.data_dest     = on_bus ? req.src_id : 4'd0;
    rsp.out_addr      = (gets || getm || to_proc || on_bus) ? req.addr : 32'd0;
    rsp.miss          = miss;
    rsp.error_code    = err;
    rsp.line_state    = next_state;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mosi_snoop_coherence_controller.sv
// ----------------------------------------------------------------------------
// mosi_snoop_coherence_controller
// mosi snooping coherence controller with a line state table in block memory
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   -------   ---------   -------------------   --------------------------
//   request   in          req_valid/req_stall   req  (msc_pkg::req_t)
//   response  out         rsp_valid/rsp_stall   rsp  (msc_pkg::rsp_t)
//
// one request per cycle sustained while the response side does not stall.
// the memory read is registered with the request; the transition stage then
// works out the transition, writes the new state back and loads the response
// register. a request to the line just updated is served by forwarding the
// new state, since the memory read does not see that write. after reset a
// clearing pass writes every line to I, one line a cycle, with req_stall held
// high. a stalled response holds the transition stage, which then stalls requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mosi_snoop_coherence_controller
  import msc_pkg::*;
#(
  parameter int unsigned NUM_LINES = NUM_LINES_DEF
) (
  input  logic clk,
  input  logic rst,

  input  logic req_valid,
  output logic req_stall,
  input  req_t req,

  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  // line index reduced modulo NUM_LINES, worked out at elaboration
  logic [IDX_W-1:0] idx_tbl [IDX_TBL_DEPTH];

  for (genvar i = 0; i < IDX_TBL_DEPTH; i++) begin : g_idx_tbl
    localparam int unsigned IDX_MOD = i % NUM_LINES;
    assign idx_tbl[i] = IDX_W'(IDX_MOD);
  end

  logic [IDX_W-1:0] req_idx;
  assign req_idx = idx_tbl[req.line_index];

  // clearing pass after reset
  logic             clr_active;
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_cnt    <= '0;
    end else if (clr_active) begin
      if (clr_cnt == IDX_W'(NUM_LINES - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // stage handshakes
  logic s1_valid;
  logic s1_fire;
  logic req_fire;
  logic rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign s1_fire   = s1_valid && rsp_free;
  assign req_stall = clr_active || (s1_valid && !s1_fire);
  assign req_fire  = req_valid && !req_stall;

  // transition stage registers
  req_t             s1_req;
  logic [IDX_W-1:0] s1_idx;
  line_state_t      s1_next;
  rsp_t             s1_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_req <= req;
      s1_idx <= req_idx;
    end
  end

  // line state memory: one write port, one registered read port
  logic [2:0]       line_mem [NUM_LINES];
  logic [2:0]       rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [2:0]       mem_wdata;

  assign mem_we    = clr_active || s1_fire;
  assign mem_waddr = clr_active ? clr_cnt : s1_idx;
  assign mem_wdata = clr_active ? 3'(ST_I) : 3'(s1_next);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_q <= line_mem[req_idx];
    end
  end

  // forwarding of a write back to the line being read in the same cycle
  logic        fwd_hit;
  line_state_t fwd_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req_fire) begin
      fwd_hit <= s1_fire && (s1_idx == req_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      fwd_state <= s1_next;
    end
  end

  logic [2:0]  cur_raw;
  line_state_t cur_state;

  assign cur_raw   = fwd_hit ? 3'(fwd_state) : rd_q;
  // a code past M reads as invalid
  assign cur_state = (cur_raw > 3'(ST_M)) ? ST_I : line_state_t'(cur_raw);

  msc_line_fsm u_fsm (
    .req        (s1_req),
    .cur_state  (cur_state),
    .next_state (s1_next),
    .rsp        (s1_rsp)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp <= s1_rsp;
    end
  end

  // checks
  `ASSERT_NEVER(a_no_wb_in_clear, clk, rst, clr_active && s1_valid,
    "transition stage busy during clearing pass")
  `ASSERT_PROP(a_fwd_state, clk, rst,
    (req_fire && s1_fire && (s1_idx == req_idx)) |=> (cur_state == $past(s1_next)),
    "back to back request to the same line missed the new state")
  `ASSERT_PROP(a_err_no_msg, clk, rst,
    (rsp_valid && (rsp.error_code != ERR_NONE)) |->
      !(rsp.issue_gets || rsp.issue_getm || rsp.data_to_proc || rsp.data_on_bus),
    "error response carries a message")
  `ASSERT_PROP(a_clr_length, clk, rst,
    $fell(clr_active) |-> ($past(clr_cnt) == IDX_W'(NUM_LINES - 1)),
    "clearing pass ended before the last line")

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mosi snooping coherence controller: directed
// walks through every line state and special case, then random traffic on a
// few busy lines, each response compared field by field with a prediction
// ----------------------------------------------------------------------------

// keeps its own copy of the line state table and the responses still due
class coherence_scoreboard;
  msc_pkg::line_state_t line_tbl[msc_pkg::NUM_LINES_DEF];
  msc_pkg::rsp_t        due_q[$];
  int unsigned          fail_count;
  int unsigned          rsp_count;

  function new();
    foreach (line_tbl[i]) line_tbl[i] = msc_pkg::ST_I;
    fail_count = 0;
    rsp_count  = 0;
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  // next state and bus actions for one request, table updated in place
  function msc_pkg::rsp_t next_response(msc_pkg::req_t r);
    int unsigned          idx;
    msc_pkg::line_state_t st;
    msc_pkg::line_state_t nx;
    msc_pkg::rsp_t        res;
    bit                   gets, getm, to_proc, on_bus, shr, miss;
    logic [1:0]           err;
    idx     = r.line_index % msc_pkg::NUM_LINES_DEF;
    st      = line_tbl[idx];
    nx      = st;
    gets    = 0;
    getm    = 0;
    to_proc = 0;
    on_bus  = 0;
    shr     = 0;
    miss    = 0;
    err     = msc_pkg::ERR_NONE;
    case (r.req_type)
      msc_pkg::RQ_LOAD, msc_pkg::RQ_STORE: begin
        case (st)
          msc_pkg::ST_I: begin
            miss = 1;
            if (r.req_type == msc_pkg::RQ_STORE) begin
              getm = 1;
              nx   = msc_pkg::ST_IM;
            end else begin
              gets = 1;
              nx   = msc_pkg::ST_IS;
            end
          end
          msc_pkg::ST_S, msc_pkg::ST_O: begin
            if (r.req_type == msc_pkg::RQ_STORE) begin
              getm = 1;
              miss = 1;
              nx   = (st == msc_pkg::ST_S) ? msc_pkg::ST_IM : msc_pkg::ST_OM;
            end else begin
              to_proc = 1;
            end
          end
          msc_pkg::ST_M: to_proc = 1;
          default: err = msc_pkg::ERR_WAIT;
        endcase
      end
      msc_pkg::RQ_GETS, msc_pkg::RQ_GETM: begin
        case (st)
          msc_pkg::ST_S: begin
            if (r.req_type == msc_pkg::RQ_GETM) nx = msc_pkg::ST_I;
          end
          msc_pkg::ST_O: begin
            shr    = 1;
            on_bus = 1;
            if (r.req_type == msc_pkg::RQ_GETM) nx = msc_pkg::ST_I;
          end
          msc_pkg::ST_OM: begin
            shr    = !r.shared_in;
            on_bus = !r.shared_in;
          end
          msc_pkg::ST_M: begin
            shr    = !r.shared_in;
            on_bus = !r.shared_in;
            nx     = (r.req_type == msc_pkg::RQ_GETM) ? msc_pkg::ST_I : msc_pkg::ST_O;
          end
          default: ;
        endcase
      end
      msc_pkg::RQ_DATA: begin
        case (st)
          msc_pkg::ST_IS: begin
            to_proc = 1;
            nx      = msc_pkg::ST_S;
          end
          msc_pkg::ST_IM, msc_pkg::ST_OM: begin
            to_proc = 1;
            nx      = msc_pkg::ST_M;
          end
          msc_pkg::ST_O: err = msc_pkg::ERR_UNEXP;
          msc_pkg::ST_M: err = msc_pkg::ERR_MOD;
          default: ;
        endcase
      end
      default: err = msc_pkg::ERR_UNEXP;
    endcase
    line_tbl[idx] = nx;

    res               = '0;
    res.issue_gets    = gets;
    res.issue_getm    = getm;
    res.data_to_proc  = to_proc;
    res.data_on_bus   = on_bus;
    res.assert_shared = shr;
    res.data_dest     = on_bus ? r.src_id : 4'd0;
    res.out_addr      = (gets || getm || to_proc || on_bus) ? r.addr : 32'd0;
    res.miss          = miss;
    res.error_code    = err;
    res.line_state    = nx;
    return res;
  endfunction

  function void note_request(msc_pkg::req_t r);
    due_q.push_back(next_response(r));
  endfunction

  task report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("response %0d %s: got %0h, want %0h",
                                rsp_count, name, got, want));
  endtask

  task check_response(msc_pkg::rsp_t got);
    msc_pkg::rsp_t want;
    if (due_q.size() == 0) begin
      report_mismatch("response with no request outstanding");
      return;
    end
    want = due_q.pop_front();
    rsp_count++;
    cmp_field("issue_gets",    32'(got.issue_gets),    32'(want.issue_gets));
    cmp_field("issue_getm",    32'(got.issue_getm),    32'(want.issue_getm));
    cmp_field("data_to_proc",  32'(got.data_to_proc),  32'(want.data_to_proc));
    cmp_field("data_on_bus",   32'(got.data_on_bus),   32'(want.data_on_bus));
    cmp_field("assert_shared", 32'(got.assert_shared), 32'(want.assert_shared));
    cmp_field("data_dest",     32'(got.data_dest),     32'(want.data_dest));
    cmp_field("out_addr",      got.out_addr,           want.out_addr);
    cmp_field("miss",          32'(got.miss),          32'(want.miss));
    cmp_field("error_code",    32'(got.error_code),    32'(want.error_code));
    cmp_field("line_state",    32'(got.line_state),    32'(want.line_state));
  endtask
endclass

module tb;
  import msc_pkg::*;

  localparam int    CLK_HALF    = 6;
  localparam int    RAND_ITEMS  = 1350;
  localparam int    DRAIN_CYC   = 8;
  // generous bound on the length of a full run
  localparam longint TIMEOUT_NS = 64'd300_000 * 2 * CLK_HALF;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // no idling on either side while set
  bit quiet = 1'b0;

  // a handful of busy lines so the random traffic walks deep into each state
  logic [7:0] hot_lines[8];

  coherence_scoreboard sb = new();

  mosi_snoop_coherence_controller #(
    .NUM_LINES(NUM_LINES_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 12 ns clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // response side stalls about a third of the time, never while quiet
  always @(negedge clk) begin
    rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 35);
  end

  // every accepted response is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // run limit, independent of the stimulus
  initial begin
    #(TIMEOUT_NS);
    $display("mosi_snoop_coherence_controller test failed");
    $finish;
  end

  function automatic req_t mk(logic [2:0] rt, logic [7:0] idx, logic [31:0] addr,
                              logic [3:0] src, logic shr);
    req_t r;
    r.req_type   = rt;
    r.line_index = idx;
    r.addr       = addr;
    r.src_id     = src;
    r.shared_in  = shr;
    return r;
  endfunction

  // mostly processor traffic and data replies on busy lines, some noise
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 22)      r.req_type = RQ_LOAD;
    else if (pick < 40) r.req_type = RQ_STORE;
    else if (pick < 55) r.req_type = RQ_GETS;
    else if (pick < 70) r.req_type = RQ_GETM;
    else if (pick < 95) r.req_type = RQ_DATA;
    else                r.req_type = 3'($urandom_range(7, 5));
    r.line_index = ($urandom_range(99) < 85) ? hot_lines[3'($urandom_range(7))]
                                             : 8'($urandom_range(255));
    r.addr      = $urandom;
    r.src_id    = 4'($urandom_range(15));
    r.shared_in = 1'($urandom_range(1));
    return r;
  endfunction

  // present one request at a falling edge, hold it until accepted
  task automatic send_request(req_t r);
    while (!quiet && $urandom_range(99) < 35) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding request has its response
  task automatic drain_requests();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    // synchronous reset first; the clearing pass follows under stall
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk on line 0: I -> IS -> S -> IM -> M -> O -> OM -> M -> I
    send_request(mk(RQ_LOAD,  8'd0, 32'h0000_0000, 4'd0,  1'b0)); // miss, gets
    send_request(mk(RQ_LOAD,  8'd0, 32'hffff_ffff, 4'd15, 1'b1)); // request while waiting
    send_request(mk(RQ_DATA,  8'd0, 32'hffff_ffff, 4'd15, 1'b1)); // fill to S
    send_request(mk(RQ_LOAD,  8'd0, 32'h1234_5678, 4'd3,  1'b0)); // hit in S
    send_request(mk(RQ_GETS,  8'd0, 32'h0000_0001, 4'd9,  1'b1)); // S stays S
    send_request(mk(RQ_STORE, 8'd0, 32'h8000_0000, 4'd0,  1'b0)); // upgrade, miss
    send_request(mk(RQ_STORE, 8'd0, 32'h0000_0000, 4'd0,  1'b0)); // store while waiting
    send_request(mk(RQ_DATA,  8'd0, 32'hdead_beef, 4'd1,  1'b0)); // IM -> M
    send_request(mk(RQ_DATA,  8'd0, 32'hdead_beef, 4'd1,  1'b0)); // data while modified
    send_request(mk(RQ_LOAD,  8'd0, 32'hffff_ffff, 4'd0,  1'b0)); // hit in M
    send_request(mk(RQ_GETS,  8'd0, 32'hffff_ffff, 4'd15, 1'b0)); // M -> O, supply
    send_request(mk(RQ_DATA,  8'd0, 32'h0000_0000, 4'd0,  1'b0)); // data while owned
    send_request(mk(RQ_GETS,  8'd0, 32'h5555_aaaa, 4'd6,  1'b1)); // O supplies anyway
    send_request(mk(RQ_STORE, 8'd0, 32'haaaa_5555, 4'd0,  1'b0)); // O -> OM
    send_request(mk(RQ_GETS,  8'd0, 32'h0f0f_0f0f, 4'd5,  1'b1)); // OM, shared already up
    send_request(mk(RQ_GETM,  8'd0, 32'hf0f0_f0f0, 4'd10, 1'b0)); // OM supplies
    send_request(mk(RQ_DATA,  8'd0, 32'h0000_0000, 4'd0,  1'b1)); // OM -> M
    send_request(mk(RQ_GETM,  8'd0, 32'hffff_ffff, 4'd15, 1'b1)); // M -> I, no supply

    // top line: snoops in I, unknown request types, a store miss and its fill
    send_request(mk(RQ_GETM,  8'd255, 32'hffff_ffff, 4'd15, 1'b1)); // nothing in I
    send_request(mk(RQ_DATA,  8'd255, 32'hffff_ffff, 4'd15, 1'b0)); // ignored in I
    send_request(mk(3'd5,     8'd255, 32'hffff_ffff, 4'd15, 1'b1));
    send_request(mk(3'd6,     8'd255, 32'h0000_0000, 4'd0,  1'b0));
    send_request(mk(3'd7,     8'd255, 32'hffff_ffff, 4'd15, 1'b1));
    send_request(mk(RQ_STORE, 8'd255, 32'h0000_0000, 4'd0,  1'b0)); // I -> IM
    send_request(mk(RQ_DATA,  8'd255, 32'h0000_0000, 4'd0,  1'b0)); // IM -> M
    drain_requests();

    // random traffic on a rotating set of busy lines
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 300 == 0) foreach (hot_lines[k]) hot_lines[k] = 8'($urandom_range(255));
      if (i == 500) quiet = 1'b1;
      if (i == 800) quiet = 1'b0;
      if (i == 300 || i == 1000) drain_requests();
      send_request(random_request());
    end
    req_valid <= 1'b0;

    // wait for the last responses, then keep watching for stray responses
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("responses still outstanding at end of run");

    if (sb.fail_count == 0) begin
      $display("mosi_snoop_coherence_controller test passed");
    end else begin
      $display("mosi_snoop_coherence_controller test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/msc_pkg.sv
hw/rtl/msc_line_fsm.sv
hw/rtl/mosi_snoop_coherence_controller.sv
test/tb.sv
